// ===== rtl/spq_pkg.sv =====
// Shared constants, types and helper functions for the scale pitch quantizer.
// No dependencies; imported by spq_table, spq_core and scale_pitch_quantizer.
package spq_pkg;

    // Fixed-point format and field widths
    localparam int FRAC_BITS   = 16;
    localparam int TABLE_DEPTH = 128;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = TBL_AW + 1;

    localparam int PITCH_W = 21;
    localparam int ENTRY_W = 19;
    localparam int DEG_W   = 8;
    localparam int OCT_W   = 8;
    localparam int NC_W    = 8;
    localparam int PER_W   = 18;
    localparam int INV_W   = 24;
    localparam int NOTE_W  = 7;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Internal datapath widths
    localparam int ROFF_W = 21;
    localparam int P_W    = PITCH_W + 1;
    localparam int PROD_W = P_W + INV_W + 1;
    localparam int K_W    = PROD_W - 2 * FRAC_BITS;
    localparam int DW     = 36;

    localparam int PITCH_MAX = 2 ** (PITCH_W - 1) - 1;
    localparam int PITCH_MIN = -(2 ** (PITCH_W - 1));
    localparam int OCT_MAX   = 2 ** (OCT_W - 1) - 1;
    localparam int OCT_MIN   = -(2 ** (OCT_W - 1));

    // Root offset: round(|root - 60| * 2^F / 12), with |d| = 3a + b
    localparam int ROOT_REF     = 60;
    localparam int RECIP3_MUL   = 171;
    localparam int RECIP3_SHIFT = 9;
    localparam int ROFF_B1      = ((1 << FRAC_BITS) + 6) / 12;
    localparam int ROFF_B2      = ((2 << FRAC_BITS) + 6) / 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NOTE_COUNT = 2'd0,
        REG_PERIOD     = 2'd1,
        REG_INV_PERIOD = 2'd2,
        REG_ROOT_NOTE  = 2'd3
    } cfg_reg_e;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUB,
        S_MULK,
        S_MULR,
        S_R,
        S_ABS,
        S_SCAN,
        S_PER,
        S_RDT,
        S_BUILD,
        S_SAT,
        S_DONE
    } state_e;

    typedef struct packed {
        logic [NC_W-1:0]   note_count;
        logic [PER_W-1:0]  period_log2;
        logic [INV_W-1:0]  inverse_period;
        logic [NOTE_W-1:0] root_note;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        note_count:     NC_W'(0),
        period_log2:    PER_W'(65536),
        inverse_period: INV_W'(65536),
        root_note:      NOTE_W'(60)
    };

    typedef struct packed {
        logic                      we;
        logic [TBL_AW-1:0]         waddr;
        logic signed [ENTRY_W-1:0] wdata;
        logic                      re;
        logic [TBL_AW-1:0]         raddr;
    } tbl_req_t;

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch;
        logic [DEG_W-1:0]          degree;
        logic signed [OCT_W-1:0]   octave;
    } res_t;

    function automatic logic [DW-1:0] abs_dw(input logic signed [DW-1:0] x);
        return x[DW-1] ? DW'(-x) : DW'(x);
    endfunction

    function automatic logic signed [ROFF_W-1:0] root_offset(input logic [NOTE_W-1:0] root);
        logic signed [NOTE_W:0]     d;
        logic [NOTE_W-1:0]          ad;
        logic [NOTE_W+8-1:0]        prod;
        logic [NOTE_W-1:0]          a;
        logic [NOTE_W-1:0]          b;
        logic signed [ROFF_W-1:0]   q;
        d    = $signed({1'b0, root}) - (NOTE_W + 1)'(ROOT_REF);
        ad   = d[NOTE_W] ? NOTE_W'(-d) : NOTE_W'(d);
        prod = (NOTE_W + 8)'(ad) * (NOTE_W + 8)'(RECIP3_MUL);
        a    = NOTE_W'(prod >> RECIP3_SHIFT);
        b    = ad - a - a - a;
        q    = $signed(ROFF_W'(a) << (FRAC_BITS - 2));
        if (b == NOTE_W'(1))
            q = q + ROFF_W'(ROFF_B1);
        else if (b == NOTE_W'(2))
            q = q + ROFF_W'(ROFF_B2);
        return d[NOTE_W] ? -q : q;
    endfunction

endpackage

// ===== rtl/spq_table.sv =====
// Scale table storage: one write port and one registered read port.
// Depends on spq_pkg for depth and entry width.
module spq_table (
    input  logic                               clk,
    input  spq_pkg::tbl_req_t                  req,
    output logic signed [spq_pkg::ENTRY_W-1:0] rdata
);
    import spq_pkg::*;

    logic signed [ENTRY_W-1:0] ram [TABLE_DEPTH];
    logic signed [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            ram[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= ram[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/spq_core.sv =====
// Quantizer sequencer: period reduction, table scan, rebuild and saturation.
// Depends on spq_pkg; drives the spq_table ports and hands results to the top.
module spq_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  spq_pkg::cfg_t                      cfg,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               mode,
    input  logic signed [spq_pkg::PITCH_W-1:0] pitch_in,
    input  logic [spq_pkg::TBL_AW-1:0]         entry_index,
    input  logic signed [spq_pkg::ENTRY_W-1:0] entry_value,
    output spq_pkg::tbl_req_t                  tbl_req,
    input  logic signed [spq_pkg::ENTRY_W-1:0] tbl_rdata,
    output logic                               res_valid,
    input  logic                               res_take,
    output spq_pkg::res_t                      res
);
    import spq_pkg::*;

    state_e state_reg, state_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             v1_reg, v1_next;
    logic             v2_reg, v2_next;
    logic [CNT_W-1:0] idx1_reg, idx1_next;
    logic [CNT_W-1:0] idx2_reg, idx2_next;

    logic signed [P_W-1:0]    pin_reg, pin_next;
    logic signed [ROFF_W-1:0] roff_reg, roff_next;
    logic signed [P_W-1:0]    p_reg, p_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [K_W-1:0]    k_reg, k_next;
    logic signed [DW-1:0]     kp_reg, kp_next;
    logic signed [DW-1:0]     r_reg, r_next;
    logic signed [DW-1:0]     rp_reg, rp_next;
    logic signed [DW-1:0]     diff_reg, diff_next;
    logic signed [DW-1:0]     base_reg, base_next;
    logic [DW-1:0]            best_reg, best_next;
    logic [CNT_W-1:0]         deg_reg, deg_next;
    logic                     up_reg, up_next;
    res_t                     res_reg, res_next;

    logic                     accept;
    logic [CNT_W-1:0]         n_eff;
    logic [PER_W-1:0]         per_eff;
    logic signed [DW-1:0]     per_dw;
    logic                     issue;
    logic                     scan_done;
    logic [DW-1:0]            dist_abs;
    logic signed [K_W:0]      oct_sum;

    assign accept    = in_valid && in_ready;
    assign n_eff     = (cfg.note_count > NC_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                             : CNT_W'(cfg.note_count);
    // zero period counts as one octave
    assign per_eff   = (cfg.period_log2 == '0) ? PER_W'(1 << FRAC_BITS) : cfg.period_log2;
    assign per_dw    = DW'($signed({1'b0, per_eff}));
    assign issue     = cnt_reg < n_eff;
    assign scan_done = !issue && !v1_reg && !v2_reg;
    assign dist_abs  = abs_dw(diff_reg);
    assign oct_sum   = $signed((K_W + 1)'(k_reg)) + $signed({{K_W{1'b0}}, up_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !mode)
                    state_next = (cfg.note_count == '0) ? S_DONE : S_SUB;
            end
            S_SUB:   state_next = S_MULK;
            S_MULK:  state_next = S_MULR;
            S_MULR:  state_next = S_R;
            S_R:     state_next = S_ABS;
            S_ABS:   state_next = S_SCAN;
            S_SCAN:
            begin
                if (scan_done)
                    state_next = S_PER;
            end
            S_PER:   state_next = S_RDT;
            S_RDT:   state_next = S_BUILD;
            S_BUILD: state_next = S_SAT;
            S_SAT:   state_next = S_DONE;
            S_DONE:
            begin
                if (res_take)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        tbl_req   = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                tbl_req.we    = accept && mode
                                && ({1'b0, entry_index} < CNT_W'(TABLE_DEPTH));
                tbl_req.waddr = entry_index;
                tbl_req.wdata = entry_value;
            end
            S_SCAN:
            begin
                tbl_req.re    = issue;
                tbl_req.raddr = cnt_reg[TBL_AW-1:0];
            end
            S_RDT:
            begin
                tbl_req.re    = deg_reg != '0;
                tbl_req.raddr = TBL_AW'(deg_reg - CNT_W'(1));
            end
            S_DONE:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next  = cnt_reg;
        v1_next   = 1'b0;
        v2_next   = 1'b0;
        idx1_next = idx1_reg;
        idx2_next = idx2_reg;
        pin_next  = pin_reg;
        roff_next = roff_reg;
        p_next    = p_reg;
        prod_next = prod_reg;
        k_next    = k_reg;
        kp_next   = kp_reg;
        r_next    = r_reg;
        rp_next   = rp_reg;
        diff_next = diff_reg;
        base_next = base_reg;
        best_next = best_reg;
        deg_next  = deg_reg;
        up_next   = up_reg;
        res_next  = res_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !mode)
                begin
                    pin_next         = P_W'(pitch_in);
                    roff_next        = root_offset(cfg.root_note);
                    res_next.pitch   = pitch_in;
                    res_next.degree  = '0;
                    res_next.octave  = '0;
                end
            end
            S_SUB:
            begin
                p_next = pin_reg - P_W'(roff_reg);
            end
            S_MULK:
            begin
                prod_next = p_reg * $signed({1'b0, cfg.inverse_period});
            end
            S_MULR:
            begin
                // floor(p * inv / 2^2F) is the upper slice of the product
                k_next  = $signed(prod_reg[PROD_W-1:2*FRAC_BITS]);
                kp_next = $signed(prod_reg[PROD_W-1:2*FRAC_BITS]) * $signed({1'b0, per_eff});
            end
            S_R:
            begin
                r_next = DW'(p_reg) - kp_reg;
            end
            S_ABS:
            begin
                best_next = abs_dw(r_reg);
                rp_next   = r_reg - per_dw;
                cnt_next  = '0;
                deg_next  = '0;
                up_next   = 1'b0;
            end
            S_SCAN:
            begin
                // read -> subtract -> compare, one entry per cycle
                if (issue)
                    cnt_next = cnt_reg + CNT_W'(1);
                v1_next   = issue;
                idx1_next = cnt_reg;
                v2_next   = v1_reg;
                idx2_next = idx1_reg;
                if (v1_reg)
                    diff_next = r_reg - DW'(tbl_rdata);
                if (v2_reg && (dist_abs < best_reg))
                begin
                    best_next = dist_abs;
                    deg_next  = idx2_reg + CNT_W'(1);
                end
            end
            S_PER:
            begin
                // next period's root beats every degree: step up one period
                if (abs_dw(rp_reg) < best_reg)
                begin
                    deg_next = '0;
                    up_next  = 1'b1;
                end
                base_next = kp_reg + DW'(roff_reg);
            end
            S_RDT:
            begin
                if (up_reg)
                    base_next = base_reg + per_dw;
            end
            S_BUILD:
            begin
                if (deg_reg != '0)
                    base_next = base_reg + DW'(tbl_rdata);
            end
            S_SAT:
            begin
                if (base_reg > DW'(PITCH_MAX))
                    res_next.pitch = PITCH_W'(PITCH_MAX);
                else if (base_reg < DW'(PITCH_MIN))
                    res_next.pitch = PITCH_W'(PITCH_MIN);
                else
                    res_next.pitch = base_reg[PITCH_W-1:0];
                res_next.degree = DEG_W'(deg_reg);
                if (oct_sum > (K_W + 1)'(OCT_MAX))
                    res_next.octave = OCT_W'(OCT_MAX);
                else if (oct_sum < (K_W + 1)'(OCT_MIN))
                    res_next.octave = OCT_W'(OCT_MIN);
                else
                    res_next.octave = oct_sum[OCT_W-1:0];
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= idx1_next;
        idx2_reg <= idx2_next;
        pin_reg  <= pin_next;
        roff_reg <= roff_next;
        p_reg    <= p_next;
        prod_reg <= prod_next;
        k_reg    <= k_next;
        kp_reg   <= kp_next;
        r_reg    <= r_next;
        rp_reg   <= rp_next;
        diff_reg <= diff_next;
        base_reg <= base_next;
        best_reg <= best_next;
        deg_reg  <= deg_next;
        up_reg   <= up_next;
        res_reg  <= res_next;
    end

    assign res = res_reg;

    // table is written only between transactions, never during a read
    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(tbl_req.we && tbl_req.re))
        else $error("table read and write in the same cycle");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_take |=> res_valid && $stable(res))
        else $error("pending result changed before hand-off");

    a_degree_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.degree <= DEG_W'(n_eff))
        else $error("chosen degree beyond note count");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> cnt_reg <= n_eff)
        else $error("scan counter ran past note count");

    a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && state_next == S_PER |=> !v1_reg && !v2_reg)
        else $error("scan left with compares in flight");

endmodule

// ===== rtl/scale_pitch_quantizer.sv =====
// Scale pitch quantizer top level: configuration registers, output register,
// and the spq_core sequencer with its spq_table memory. Depends on spq_pkg.
//
// A pitch transaction (mode 0) is offset by the root, reduced into one period
// and matched against the table before its result is valid. The table scan
// reads one entry per cycle through the scale memory's single read port and
// runs a two-stage subtract/compare behind it. With note_count 0
// a pitch passes through unchanged, with degree and octave zero. A load
// transaction (mode 1) writes one table entry in the cycle
// it is accepted and produces no result. A new transaction is accepted as
// soon as the previous result has moved into the output register, even while
// that result waits for out_ready. Table entries are undefined until loaded;
// load every degree in use before sending pitches. Configuration writes take
// effect at once.
module scale_pitch_quantizer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [spq_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [spq_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  mode,
    input  logic signed [spq_pkg::PITCH_W-1:0]    pitch_in,
    input  logic [spq_pkg::TBL_AW-1:0]            entry_index,
    input  logic signed [spq_pkg::ENTRY_W-1:0]    entry_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [spq_pkg::PITCH_W-1:0]    pitch_out,
    output logic [spq_pkg::DEG_W-1:0]             degree,
    output logic signed [spq_pkg::OCT_W-1:0]      octave
);
    import spq_pkg::*;

    cfg_t     cfg_reg;
    tbl_req_t tbl_req;
    logic signed [ENTRY_W-1:0] tbl_rdata;
    logic     res_valid;
    logic     res_take;
    res_t     res;
    logic     out_valid_reg, out_valid_next;
    res_t     out_reg, out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_e'(cfg_index))
                REG_NOTE_COUNT: cfg_reg.note_count     <= cfg_data[NC_W-1:0];
                REG_PERIOD:     cfg_reg.period_log2    <= cfg_data[PER_W-1:0];
                REG_INV_PERIOD: cfg_reg.inverse_period <= cfg_data[INV_W-1:0];
                REG_ROOT_NOTE:  cfg_reg.root_note      <= cfg_data[NOTE_W-1:0];
                default:        cfg_reg                <= cfg_reg;
            endcase
        end
    end

    spq_table u_table (
        .clk   (clk),
        .req   (tbl_req),
        .rdata (tbl_rdata)
    );

    spq_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .pitch_in    (pitch_in),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .tbl_req     (tbl_req),
        .tbl_rdata   (tbl_rdata),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res)
    );

    // output register frees the core while a result waits downstream
    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign pitch_out = out_reg.pitch;
    assign degree    = out_reg.degree;
    assign octave    = out_reg.octave;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for scale_pitch_quantizer: a scoreboard class predicts each
// quantized pitch; directed and randomized traffic drives both valid/ready channels.
// Depends on spq_pkg and the scale_pitch_quantizer RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int   CLK_PERIOD   = 12;
    localparam int   RESET_CYCLES = 6;
    localparam int   ITEM_TARGET  = 1700;
    localparam int   DRAIN_CYCLES = 160;
    localparam int   HOLD_CYCLES  = 3000;
    localparam int   STALL_LIMIT  = 20000;
    localparam int   SEMITONES    = 12;
    localparam int   ENTRY_MAX    = (1 << (ENTRY_W - 1)) - 1;
    localparam int   ENTRY_MIN    = -(1 << (ENTRY_W - 1));
    localparam int   INV_MAX      = (1 << INV_W) - 1;
    localparam int   PER_MAX      = (1 << PER_W) - 1;
    localparam logic MODE_QUANT   = 1'b0;
    localparam logic MODE_LOAD    = 1'b1;

    // Predicts quantizer results and holds them until the block delivers them.
    class quant_scoreboard;
        logic signed [ENTRY_W-1:0] scale_tbl [TABLE_DEPTH];
        logic [NC_W-1:0]           note_count;
        logic [PER_W-1:0]          period;
        logic [INV_W-1:0]          inv_period;
        logic [NOTE_W-1:0]         root;
        res_t                      expected_q[$];
        int                        errors;

        function new();
            note_count = CFG_RESET.note_count;
            period     = CFG_RESET.period_log2;
            inv_period = CFG_RESET.inverse_period;
            root       = CFG_RESET.root_note;
            errors     = 0;
        endfunction

        function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_NOTE_COUNT: note_count = data[NC_W-1:0];
                REG_PERIOD:     period     = data[PER_W-1:0];
                REG_INV_PERIOD: inv_period = data[INV_W-1:0];
                REG_ROOT_NOTE:  root       = data[NOTE_W-1:0];
                default: ;
            endcase
        endfunction

        function longint magnitude(longint x);
            return (x < 0) ? -x : x;
        endfunction

        function longint clamp(longint x, longint lo, longint hi);
            return (x < lo) ? lo : ((x > hi) ? hi : x);
        endfunction

        function res_t quantize(logic signed [PITCH_W-1:0] pin);
            res_t   res;
            longint per, rel, roff, p, k, r, best, dist_abs, q, oct;
            int     n, deg;
            if (note_count == 0) begin
                res.pitch  = pin;
                res.degree = '0;
                res.octave = '0;
                return res;
            end
            n    = (note_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(note_count);
            per  = (period == 0) ? (longint'(1) << FRAC_BITS) : longint'(period);
            // root offset rounded to nearest, away from zero on magnitude
            rel  = longint'(root) - ROOT_REF;
            roff = ((magnitude(rel) << FRAC_BITS) + SEMITONES / 2) / SEMITONES;
            if (rel < 0)
                roff = -roff;
            p    = longint'(pin) - roff;
            k    = (p * longint'(inv_period)) >>> (2 * FRAC_BITS);
            r    = p - k * per;
            deg  = 0;
            best = magnitude(r);
            for (int i = 0; i < n; i++) begin
                dist_abs = magnitude(r - longint'(scale_tbl[i]));
                if (dist_abs < best) begin
                    best = dist_abs;
                    deg  = i + 1;
                end
            end
            oct = k;
            if (magnitude(r - per) < best) begin
                deg = 0;
                oct = k + 1;
            end
            q = oct * per + roff;
            if (deg > 0)
                q += longint'(scale_tbl[deg - 1]);
            res.pitch  = PITCH_W'(clamp(q, PITCH_MIN, PITCH_MAX));
            res.degree = DEG_W'(deg);
            res.octave = OCT_W'(clamp(oct, OCT_MIN, OCT_MAX));
            return res;
        endfunction

        function void note_input(logic m, logic signed [PITCH_W-1:0] pin,
                                 logic [TBL_AW-1:0] idx, logic signed [ENTRY_W-1:0] val);
            if (m == MODE_LOAD)
                scale_tbl[idx] = val;
            else
                expected_q.push_back(quantize(pin));
        endfunction

        function void check_result(logic signed [PITCH_W-1:0] p, logic [DEG_W-1:0] d,
                                   logic signed [OCT_W-1:0] o);
            res_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result pitch_out %0d degree %0d octave %0d",
                         $time, p, d, o);
                return;
            end
            want = expected_q.pop_front();
            if (p !== want.pitch) begin
                errors++;
                $display("%0t: pitch_out expected %0d, actual %0d", $time, want.pitch, p);
            end
            if (d !== want.degree) begin
                errors++;
                $display("%0t: degree expected %0d, actual %0d", $time, want.degree, d);
            end
            if (o !== want.octave) begin
                errors++;
                $display("%0t: octave expected %0d, actual %0d", $time, want.octave, o);
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic                      mode;
    logic signed [PITCH_W-1:0] pitch_in;
    logic [TBL_AW-1:0]         entry_index;
    logic signed [ENTRY_W-1:0] entry_value;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [PITCH_W-1:0] pitch_out;
    logic [DEG_W-1:0]          degree;
    logic signed [OCT_W-1:0]   octave;

    quant_scoreboard sb;
    int              items_sent;
    int              stall_count;
    bit              no_gaps;
    bit              hold_req;

    scale_pitch_quantizer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .pitch_in    (pitch_in),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pitch_out   (pitch_out),
        .degree      (degree),
        .octave      (octave)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 16);
        return $urandom_range(30, 250);
    endfunction

    function automatic int clip(int v, int lo, int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Both channels sampled at the rising edge, before the block updates.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_input(mode, pitch_in, entry_index, entry_value);
            if (out_valid && out_ready)
                sb.check_result(pitch_out, degree, octave);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_count <= 0;
        else if (stall_count >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
        else
            stall_count <= stall_count + 1;
    end

    // Result sink: random back-pressure, plus a long hold-off on request.
    initial
    begin
        int gap;
        int burst;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_req) begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else begin
                gap   = pick_gap();
                burst = $urandom_range(1, 20);
                repeat (gap) begin
                    @(negedge clk);
                    out_ready <= 1'b0;
                end
                repeat (burst) begin
                    @(negedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    task automatic send_item(input logic m, input int pin, input int idx, input int val);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        mode        <= m;
        pitch_in    <= PITCH_W'(pin);
        entry_index <= TBL_AW'(idx);
        entry_value <= ENTRY_W'(val);
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic send_pitch(input int pin);
        send_item(MODE_QUANT, pin, $urandom_range(0, TABLE_DEPTH - 1),
                  int'($urandom_range(0, 2 * ENTRY_MAX + 1)) + ENTRY_MIN);
    endtask

    task automatic send_load(input int idx, input int val);
        send_item(MODE_LOAD, int'($urandom_range(0, 2 * PITCH_MAX + 1)) + PITCH_MIN, idx, val);
    endtask

    // Drop valid, wait for every expected result, then let the block go quiet.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic program_reg(input cfg_reg_e idx, input int unsigned value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        sb.write_reg(idx, CFG_DATA_W'(value));
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic directed();
        // pass-through with reset settings; loads at the index and value extremes
        send_pitch(PITCH_MAX);
        send_pitch(PITCH_MIN);
        send_pitch(0);
        send_load(TABLE_DEPTH - 1, ENTRY_MIN);
        send_load(0, ENTRY_MAX);
        settle();
        program_reg(REG_NOTE_COUNT, 3);
        program_reg(REG_PERIOD, 65536);
        program_reg(REG_INV_PERIOD, 65536);
        program_reg(REG_ROOT_NOTE, 60);
        send_load(0, 16384);
        send_load(1, 32768);
        send_load(2, 49152);
        send_pitch(8192);       // tie between root and first degree
        send_pitch(24576);      // tie between two degrees
        send_pitch(60000);      // snaps up to next period's root
        send_pitch(-1);
        send_pitch(PITCH_MAX);
        send_pitch(PITCH_MIN);
        settle();
        // zero period and zero reciprocal, highest root
        program_reg(REG_ROOT_NOTE, 127);
        program_reg(REG_PERIOD, 0);
        program_reg(REG_INV_PERIOD, 0);
        send_pitch(100000);
        send_pitch(-100000);
        settle();
        program_reg(REG_ROOT_NOTE, 0);
        program_reg(REG_PERIOD, PER_MAX);
        program_reg(REG_INV_PERIOD, INV_MAX);
        send_pitch(PITCH_MAX);
        send_pitch(PITCH_MIN);
        settle();
    endtask

    task automatic run_phase(input int phase_no);
        int  r, n, n_eff, per, per_eff, inv, root, roff, step, jit;
        int  npitch, p, d, o, v, mid;
        bit  noisy;
        longint recip;
        r = $urandom_range(0, 99);
        if (r < 8)
            n = 0;
        else if (r < 78)
            n = $urandom_range(1, 16);
        else if (r < 90)
            n = $urandom_range(17, TABLE_DEPTH - 1);
        else if (r < 95)
            n = TABLE_DEPTH;
        else
            n = $urandom_range(TABLE_DEPTH + 1, 255);
        r = $urandom_range(0, 99);
        if (r < 40)
            per = 65536;
        else if (r < 90)
            per = $urandom_range(1024, PER_MAX);
        else if (r < 94)
            per = 1;
        else if (r < 97)
            per = PER_MAX;
        else
            per = 0;
        if (phase_no == 0) begin
            n   = TABLE_DEPTH;
            per = 1;
        end
        else if (phase_no == 1) begin
            n   = 255;
            per = PER_MAX;
        end
        per_eff = (per == 0) ? (1 << FRAC_BITS) : per;
        recip   = ((longint'(1) << (2 * FRAC_BITS)) + per_eff / 2) / per_eff;
        inv     = (recip > INV_MAX) ? INV_MAX : int'(recip);
        if ($urandom_range(0, 9) == 0)
            inv = $urandom_range(0, INV_MAX);
        if (phase_no == 1)
            inv = 1;
        root  = $urandom_range(0, 127);
        n_eff = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;

        program_reg(REG_NOTE_COUNT, n);
        program_reg(REG_PERIOD, per);
        program_reg(REG_INV_PERIOD, inv);
        program_reg(REG_ROOT_NOTE, root);
        no_gaps = ($urandom_range(0, 6) == 0);
        if (phase_no == 3 || $urandom_range(0, 19) == 0)
            hold_req = 1'b1;

        // ascending scale inside one period, or an arbitrary table now and then
        noisy = (phase_no == 0) || ($urandom_range(0, 9) == 0);
        step  = per_eff / (n_eff + 1);
        for (int i = 0; i < n_eff; i++) begin
            jit = step / 4;
            if (noisy)
                v = int'($urandom_range(0, 2 * ENTRY_MAX + 1)) + ENTRY_MIN;
            else
                v = step * (i + 1) + int'($urandom_range(0, 2 * jit)) - jit;
            send_load(i, clip(v, ENTRY_MIN, ENTRY_MAX));
        end

        roff   = (root - ROOT_REF) * (1 << FRAC_BITS) / SEMITONES;
        npitch = (n_eff >= 64) ? $urandom_range(4, 10) : $urandom_range(20, 70);
        for (int i = 0; i < npitch; i++) begin
            r = $urandom_range(0, 99);
            o = int'($urandom_range(0, 8)) - 4;
            d = (n_eff > 0) ? $urandom_range(0, n_eff - 1) : 0;
            if (r < 15)
                p = int'($urandom_range(0, 2 * PITCH_MAX + 1)) + PITCH_MIN;
            else if (r < 20)
                p = $urandom_range(0, 1) ? PITCH_MAX : PITCH_MIN;
            else if (r < 45 || n_eff == 0)
                p = roff + int'($urandom_range(0, 8 * per_eff)) - 4 * per_eff;
            else if (r < 75)
                p = roff + o * per_eff + int'(sb.scale_tbl[d]) + int'($urandom_range(0, 4)) - 2;
            else begin
                if (d + 1 < n_eff)
                    mid = (int'(sb.scale_tbl[d]) + int'(sb.scale_tbl[d + 1])) / 2;
                else
                    mid = (int'(sb.scale_tbl[d]) + per_eff) / 2;
                p = roff + o * per_eff + mid;
            end
            send_pitch(clip(p, PITCH_MIN, PITCH_MAX));
            // stray table write in the middle of pitch traffic
            if ($urandom_range(0, 24) == 0)
                send_load($urandom_range(0, TABLE_DEPTH - 1),
                          int'($urandom_range(0, 2 * ENTRY_MAX + 1)) + ENTRY_MIN);
        end
        settle();
    endtask

    initial
    begin
        int phase_no;
        sb          = new();
        rst_n       = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = REG_NOTE_COUNT;
        cfg_data    = '0;
        in_valid    = 1'b0;
        mode        = MODE_QUANT;
        pitch_in    = '0;
        entry_index = '0;
        entry_value = '0;
        hold_req    = 1'b0;
        no_gaps     = 1'b0;
        items_sent  = 0;
        stall_count = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed();
        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            run_phase(phase_no);
            phase_no++;
        end
        settle();

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
